>>> hdl/sdm_pkg.sv
// ----------------------------------------------------------------------------
// sdm_pkg
// Types, widths and tables shared by the staggered diffusion matrix row block
// ----------------------------------------------------------------------------
package sdm_pkg;

    localparam int ROW_W      = 23;
    localparam int CNT_W      = 8;
    localparam int DIM_W      = CNT_W + 1;
    localparam int XY_W       = 2 * CNT_W + 1;
    localparam int BLK_W      = 3 * CNT_W + 1;
    localparam int TOT_W      = BLK_W + 2;
    localparam int QUO_W      = CNT_W;
    localparam int TRY_W      = XY_W + QUO_W;
    localparam int COEF_W     = 64;
    localparam int KIND_W     = 3;
    localparam int IDX_W      = 3;
    localparam int REG_IDX_W  = 3;
    localparam int NB_N       = 6;
    localparam int DIV_STAGES = 2 * QUO_W;

    localparam logic [COEF_W-1:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CELLS_X,
        REG_CELLS_Y,
        REG_CELLS_Z,
        REG_DIAG_COEF,
        REG_X_COEF,
        REG_Y_COEF,
        REG_Z_COEF
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDENTITY,
        KIND_DIAG,
        KIND_X,
        KIND_Y,
        KIND_Z
    } kind_t;

    typedef enum logic [1:0] {
        COMP_U,
        COMP_V,
        COMP_W
    } comp_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             err;
        comp_t            comp;
        logic [ROW_W-1:0] rem;
        logic [QUO_W-1:0] k;
        logic [QUO_W-1:0] j;
    } stage_t;

    typedef struct packed {
        kind_t kind;
        logic  neg;
    } nb_t;

    // neighbour order per component, entry 1 to 6 after the diagonal
    function automatic nb_t nb_order(comp_t comp, logic [IDX_W-1:0] n);
        nb_t r;
        r.kind = KIND_X;
        r.neg  = 1'b0;
        if (comp == COMP_V)
        begin
            case (n)
                3'd1:    begin r.kind = KIND_Y; r.neg = 1'b0; end
                3'd2:    begin r.kind = KIND_Y; r.neg = 1'b1; end
                3'd3:    begin r.kind = KIND_Z; r.neg = 1'b1; end
                3'd4:    begin r.kind = KIND_Z; r.neg = 1'b0; end
                3'd5:    begin r.kind = KIND_X; r.neg = 1'b0; end
                3'd6:    begin r.kind = KIND_X; r.neg = 1'b1; end
                default: begin r.kind = KIND_X; r.neg = 1'b0; end
            endcase
        end
        else
        begin
            case (n)
                3'd1:    begin r.kind = KIND_X; r.neg = 1'b0; end
                3'd2:    begin r.kind = KIND_X; r.neg = 1'b1; end
                3'd3:    begin r.kind = KIND_Y; r.neg = 1'b0; end
                3'd4:    begin r.kind = KIND_Y; r.neg = 1'b1; end
                3'd5:    begin r.kind = KIND_Z; r.neg = 1'b0; end
                3'd6:    begin r.kind = KIND_Z; r.neg = 1'b1; end
                default: begin r.kind = KIND_X; r.neg = 1'b0; end
            endcase
        end
        return r;
    endfunction

    function automatic logic [XY_W-1:0] pick_xy(comp_t comp, logic [XY_W-1:0] a,
                                                logic [XY_W-1:0] b, logic [XY_W-1:0] c);
        logic [XY_W-1:0] r;
        case (comp)
            COMP_U:  r = a;
            COMP_V:  r = b;
            COMP_W:  r = c;
            default: r = a;
        endcase
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(comp_t comp, logic [DIM_W-1:0] a,
                                                  logic [DIM_W-1:0] b, logic [DIM_W-1:0] c);
        logic [DIM_W-1:0] r;
        case (comp)
            COMP_U:  r = a;
            COMP_V:  r = b;
            COMP_W:  r = c;
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/staggered_diffusion_matrix_rows.sv
// ----------------------------------------------------------------------------
// staggered_diffusion_matrix_rows
// Emits the nonzero entries of one row of the staggered-grid diffusion matrix
// ----------------------------------------------------------------------------
// a row passes the input register, split, division stages and beat emitter
// to the output register; interior rows have 7 beats, wall or error rows 1,
//   sent by the output register one beat per cycle while out_ready is high
// an item enters every cycle while the beat emitter keeps up
// reset: asynchronous active low, clears valid bits and config to reset values
// derived sizes settle via cx/cy/cz, xy products, block sizes, then offsets
module staggered_diffusion_matrix_rows #(
    parameter int MAX_CELLS = 128
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    write_enable,
    input  logic [sdm_pkg::REG_IDX_W-1:0]           register_index,
    input  logic [sdm_pkg::COEF_W-1:0]              write_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [sdm_pkg::ROW_W-1:0]               row_index,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [sdm_pkg::ROW_W-1:0]               column_index,
    output logic [sdm_pkg::COEF_W-1:0]              coefficient,
    output logic [sdm_pkg::KIND_W-1:0]              coefficient_kind,
    output logic                                    is_last,
    output logic                                    row_error
);

    localparam int RW = sdm_pkg::ROW_W;
    localparam int DW = sdm_pkg::DIM_W;
    localparam int XW = sdm_pkg::XY_W;
    localparam int BW = sdm_pkg::BLK_W;
    localparam int TW = sdm_pkg::TOT_W;
    localparam int NS = sdm_pkg::DIV_STAGES;

    function automatic logic [DW-1:0] clamp_cells(logic [sdm_pkg::CNT_W-1:0] v);
        logic [DW-1:0] r;
        r = DW'(v);
        if (v == '0)
        begin
            r = DW'(1);
        end
        else if (32'(v) > MAX_CELLS)
        begin
            r = DW'(MAX_CELLS);
        end
        return r;
    endfunction

    // config registers
    logic [sdm_pkg::CNT_W-1:0]  cells_x_reg, cells_y_reg, cells_z_reg;
    logic [sdm_pkg::COEF_W-1:0] diag_reg, xcoef_reg, ycoef_reg, zcoef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= sdm_pkg::CNT_W'(1);
            cells_y_reg <= sdm_pkg::CNT_W'(1);
            cells_z_reg <= sdm_pkg::CNT_W'(1);
            diag_reg    <= '0;
            xcoef_reg   <= '0;
            ycoef_reg   <= '0;
            zcoef_reg   <= '0;
        end
        else if (write_enable)
        begin
            case (sdm_pkg::cfg_reg_t'(register_index))
                sdm_pkg::REG_CELLS_X:   cells_x_reg <= write_data[sdm_pkg::CNT_W-1:0];
                sdm_pkg::REG_CELLS_Y:   cells_y_reg <= write_data[sdm_pkg::CNT_W-1:0];
                sdm_pkg::REG_CELLS_Z:   cells_z_reg <= write_data[sdm_pkg::CNT_W-1:0];
                sdm_pkg::REG_DIAG_COEF: diag_reg    <= write_data;
                sdm_pkg::REG_X_COEF:    xcoef_reg   <= write_data;
                sdm_pkg::REG_Y_COEF:    ycoef_reg   <= write_data;
                sdm_pkg::REG_Z_COEF:    zcoef_reg   <= write_data;
                default:                ;
            endcase
        end
    end

    // derived grid sizes
    logic [DW-1:0] cx_reg, cy_reg, cz_reg;
    logic [XW-1:0] dxy_u_reg, dxy_v_reg, dxy_w_reg;
    logic [BW-1:0] size_u_reg, size_v_reg, size_w_reg;
    logic [TW-1:0] su_reg, suv_reg, total_reg;
    logic [DW-1:0] nx_u, nx_v, ny_u, ny_v, nz_u, nz_w;

    assign nx_u = cx_reg + DW'(1);
    assign nx_v = cx_reg;
    assign ny_u = cy_reg;
    assign ny_v = cy_reg + DW'(1);
    assign nz_u = cz_reg;
    assign nz_w = cz_reg + DW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= DW'(1);
            cy_reg     <= DW'(1);
            cz_reg     <= DW'(1);
            dxy_u_reg  <= XW'(2);
            dxy_v_reg  <= XW'(2);
            dxy_w_reg  <= XW'(1);
            size_u_reg <= BW'(2);
            size_v_reg <= BW'(2);
            size_w_reg <= BW'(2);
            su_reg     <= TW'(2);
            suv_reg    <= TW'(4);
            total_reg  <= TW'(6);
        end
        else
        begin
            cx_reg     <= clamp_cells(cells_x_reg);
            cy_reg     <= clamp_cells(cells_y_reg);
            cz_reg     <= clamp_cells(cells_z_reg);
            dxy_u_reg  <= XW'(nx_u) * XW'(ny_u);
            dxy_v_reg  <= XW'(nx_v) * XW'(ny_v);
            dxy_w_reg  <= XW'(nx_v) * XW'(ny_u);
            size_u_reg <= BW'(dxy_u_reg) * BW'(nz_u);
            size_v_reg <= BW'(dxy_v_reg) * BW'(nz_u);
            size_w_reg <= BW'(dxy_w_reg) * BW'(nz_w);
            su_reg     <= TW'(size_u_reg);
            suv_reg    <= TW'(size_u_reg) + TW'(size_v_reg);
            total_reg  <= TW'(size_u_reg) + TW'(size_v_reg) + TW'(size_w_reg);
        end
    end

    // pipeline control
    logic adv;
    logic out_load;
    logic em_last;

    logic          in_vld_reg;
    logic [RW-1:0] in_row_reg;

    sdm_pkg::stage_t split_next;
    sdm_pkg::stage_t p_reg  [0:NS];
    sdm_pkg::stage_t p_next [0:NS];
    logic [NS:0]     p_vld_reg;

    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            p_vld_reg  <= '0;
        end
        else if (adv)
        begin
            in_vld_reg <= in_valid;
            p_vld_reg  <= {p_vld_reg[NS-1:0], in_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_row_reg <= row_index;
            for (int s = 0; s <= NS; s++)
            begin
                p_reg[s] <= p_next[s];
            end
        end
    end

    // component split and block offset
    always_comb
    begin
        logic [TW-1:0] row_w;
        logic [TW-1:0] base;
        row_w           = TW'(in_row_reg);
        base            = '0;
        split_next.row  = in_row_reg;
        split_next.err  = (row_w >= total_reg);
        split_next.comp = sdm_pkg::COMP_U;
        split_next.k    = '0;
        split_next.j    = '0;
        if (row_w < su_reg)
        begin
            split_next.comp = sdm_pkg::COMP_U;
            base            = '0;
        end
        else if (row_w < suv_reg)
        begin
            split_next.comp = sdm_pkg::COMP_V;
            base            = su_reg;
        end
        else
        begin
            split_next.comp = sdm_pkg::COMP_W;
            base            = suv_reg;
        end
        split_next.rem = RW'(row_w - base);
    end

    // restoring division, one quotient bit per stage: k first, then j
    always_comb
    begin
        logic [XW-1:0]                 dv;
        logic [sdm_pkg::TRY_W-1:0]     sh;
        logic                          fits;
        logic [$clog2(sdm_pkg::QUO_W)-1:0] bitn;
        p_next[0] = split_next;
        for (int s = 0; s < NS; s++)
        begin
            p_next[s+1] = p_reg[s];
            if (s < sdm_pkg::QUO_W)
            begin
                dv   = sdm_pkg::pick_xy(p_reg[s].comp, dxy_u_reg, dxy_v_reg, dxy_w_reg);
                bitn = ($clog2(sdm_pkg::QUO_W))'(sdm_pkg::QUO_W - 1 - s);
            end
            else
            begin
                dv   = XW'(sdm_pkg::pick_dim(p_reg[s].comp, nx_u, nx_v, nx_v));
                bitn = ($clog2(sdm_pkg::QUO_W))'(2 * sdm_pkg::QUO_W - 1 - s);
            end
            sh   = sdm_pkg::TRY_W'(dv) << bitn;
            fits = (sdm_pkg::TRY_W'(p_reg[s].rem) >= sh);
            if (fits)
            begin
                p_next[s+1].rem = p_reg[s].rem - RW'(sh);
            end
            if (s < sdm_pkg::QUO_W)
            begin
                p_next[s+1].k[bitn] = fits;
            end
            else
            begin
                p_next[s+1].j[bitn] = fits;
            end
        end
    end

    // beat emitter
    sdm_pkg::stage_t                em_reg;
    logic                           em_vld_reg;
    logic                           em_single_reg;
    logic [sdm_pkg::IDX_W-1:0]      em_idx_reg;
    logic                           wall_next;

    always_comb
    begin
        sdm_pkg::stage_t  t;
        logic [DW-1:0]    nx, ny, nz;
        t  = p_reg[NS];
        nx = sdm_pkg::pick_dim(t.comp, nx_u, nx_v, nx_v);
        ny = sdm_pkg::pick_dim(t.comp, ny_u, ny_v, ny_u);
        nz = sdm_pkg::pick_dim(t.comp, nz_u, nz_u, nz_w);
        wall_next = (t.rem == '0) || (t.rem == RW'(nx - DW'(1)))
                 || (t.j == '0) || (DW'(t.j) == ny - DW'(1))
                 || (t.k == '0) || (DW'(t.k) == nz - DW'(1));
    end

    assign em_last  = em_single_reg || (em_idx_reg == sdm_pkg::IDX_W'(sdm_pkg::NB_N));
    assign out_load = em_vld_reg && (!out_valid || out_ready);
    assign adv      = !em_vld_reg || (out_load && em_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_vld_reg <= 1'b0;
            em_idx_reg <= '0;
        end
        else if (adv)
        begin
            em_vld_reg <= p_vld_reg[NS];
            em_idx_reg <= '0;
        end
        else if (out_load)
        begin
            em_idx_reg <= em_idx_reg + sdm_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            em_reg        <= p_reg[NS];
            em_single_reg <= p_reg[NS].err || wall_next;
        end
    end

    // entry select
    logic [RW-1:0]              col_next;
    logic [sdm_pkg::COEF_W-1:0] coef_next;
    sdm_pkg::kind_t             kind_next;
    logic                       last_next;

    always_comb
    begin
        sdm_pkg::nb_t nb;
        logic [RW-1:0] off;
        nb  = sdm_pkg::nb_order(em_reg.comp, em_idx_reg);
        case (nb.kind)
            sdm_pkg::KIND_X: off = RW'(1);
            sdm_pkg::KIND_Y: off = RW'(sdm_pkg::pick_dim(em_reg.comp, nx_u, nx_v, nx_v));
            sdm_pkg::KIND_Z: off = RW'(sdm_pkg::pick_xy(em_reg.comp, dxy_u_reg, dxy_v_reg,
                                                         dxy_w_reg));
            default:         off = '0;
        endcase
        if (em_single_reg)
        begin
            col_next  = em_reg.row;
            coef_next = em_reg.err ? '0 : sdm_pkg::ONE_BITS;
            kind_next = sdm_pkg::KIND_IDENTITY;
            last_next = 1'b1;
        end
        else if (em_idx_reg == '0)
        begin
            col_next  = em_reg.row;
            coef_next = diag_reg;
            kind_next = sdm_pkg::KIND_DIAG;
            last_next = 1'b0;
        end
        else
        begin
            col_next  = nb.neg ? em_reg.row - off : em_reg.row + off;
            kind_next = nb.kind;
            last_next = (em_idx_reg == sdm_pkg::IDX_W'(sdm_pkg::NB_N));
            case (nb.kind)
                sdm_pkg::KIND_X: coef_next = xcoef_reg;
                sdm_pkg::KIND_Y: coef_next = ycoef_reg;
                sdm_pkg::KIND_Z: coef_next = zcoef_reg;
                default:         coef_next = '0;
            endcase
        end
    end

    // output register
    logic                        out_vld_reg;
    logic [RW-1:0]               col_reg;
    logic [sdm_pkg::COEF_W-1:0]  coef_reg;
    logic [sdm_pkg::KIND_W-1:0]  kind_reg;
    logic                        last_reg;
    logic                        err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            col_reg  <= col_next;
            coef_reg <= coef_next;
            kind_reg <= kind_next;
            last_reg <= last_next;
            err_reg  <= em_reg.err & em_single_reg;
        end
    end

    assign out_valid        = out_vld_reg;
    assign column_index     = col_reg;
    assign coefficient      = coef_reg;
    assign coefficient_kind = kind_reg;
    assign is_last          = last_reg;
    assign row_error        = err_reg;

endmodule

>>> hdl/sdm_checker.sv
// ----------------------------------------------------------------------------
// sdm_checker
// Port-level checks on the beats of the diffusion matrix row block
// ----------------------------------------------------------------------------
module sdm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [sdm_pkg::ROW_W-1:0]     column_index,
    input  logic [sdm_pkg::COEF_W-1:0]    coefficient,
    input  logic [sdm_pkg::KIND_W-1:0]    coefficient_kind,
    input  logic                          is_last,
    input  logic                          row_error
);

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(column_index)
                                  && $stable(coefficient))
        else $error("stalled beat changed");

    // error beat is a lone zero identity entry
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_error |-> is_last && coefficient == '0
            && coefficient_kind == sdm_pkg::KIND_IDENTITY)
        else $error("bad error beat");

    // wall row carries one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !row_error && coefficient_kind == sdm_pkg::KIND_IDENTITY
            |-> is_last && coefficient == sdm_pkg::ONE_BITS)
        else $error("bad identity beat");

    // entries of a row leave without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !is_last |=> out_valid)
        else $error("gap inside row");

endmodule

bind staggered_diffusion_matrix_rows sdm_checker u_sdm_checker (.*);
